[src/srap_pkg.sv]
// Shared types and constants for the STUN response attribute parser.
// Used by srap_parser and stun_response_attribute_parser; no dependencies.
`default_nettype none

package srap_pkg;

   // Fixed message layout
   localparam int unsigned HdrBytes       = 20;
   localparam int unsigned AttrHdrBytes   = 4;
   localparam int unsigned MappedValueLen = 8;
   localparam int unsigned WantedReset    = 1;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SHORT     = 2'd1,
      STATUS_TRUNC_HDR = 2'd2,
      STATUS_OVERRUN   = 2'd3
   } status_type;

   // One parse result, as it leaves the parser core
   typedef struct packed {
      logic [31:0] mapped_addr;
      logic [15:0] mapped_port;
      logic        found;
      logic [10:0] payload_length;
      status_type  status;
   } result_type;

endpackage

`default_nettype wire

[src/srap_parser.sv]
// Per-datagram parse state: byte counter, header length, attribute walk.
// Depends on srap_pkg; produces the result for a final byte combinationally.
`default_nettype none

module srap_parser #(
   parameter int unsigned MAX_PAYLOAD_BYTES = 2048
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  byte_valid,
   input  wire logic [7:0]            data_byte,
   input  wire logic                  last_byte,
   input  wire logic [15:0]           wanted_attr_type,
   output srap_pkg::result_type       result
);

   localparam int unsigned CountW = $clog2(MAX_PAYLOAD_BYTES);
   localparam int unsigned ExtW   = (CountW > 11) ? CountW : 11;
   localparam logic [CountW-1:0] Limit = CountW'(MAX_PAYLOAD_BYTES - 1);

   logic [CountW-1:0] byte_count_ff, byte_count_in;
   logic [15:0]       hdr_len_ff, hdr_len_in;
   logic [16:0]       attr_offset_ff, attr_offset_in;
   logic [15:0]       attr_type_ff, attr_type_in;
   logic [15:0]       attr_len_ff, attr_len_in;
   logic [47:0]       pending_ff, pending_in;
   logic [47:0]       port_addr_ff, port_addr_in;
   logic              found_ff, found_in;

   logic [16:0]       idx_ext;
   logic [16:0]       offset_inc;
   logic [ExtW-1:0]   count_ext;

   // Next-state logic for one accepted request byte
   always_comb begin
      byte_count_in  = byte_count_ff;
      hdr_len_in     = hdr_len_ff;
      attr_offset_in = attr_offset_ff;
      attr_type_in   = attr_type_ff;
      attr_len_in    = attr_len_ff;
      pending_in     = pending_ff;
      port_addr_in   = port_addr_ff;
      found_in       = found_ff;
      idx_ext        = 17'(byte_count_ff);
      offset_inc     = attr_offset_ff + 17'd1;
      count_ext      = '0;
      result         = '0;

      if (byte_valid) begin
         if (byte_count_ff < Limit) begin
            byte_count_in = byte_count_ff + CountW'(1);
            if (byte_count_ff == CountW'(2) || byte_count_ff == CountW'(3)) begin
               hdr_len_in = {hdr_len_ff[7:0], data_byte};
            end else if (idx_ext >= 17'(srap_pkg::HdrBytes) &&
                         (idx_ext - 17'(srap_pkg::HdrBytes)) < {1'b0, hdr_len_ff}) begin
               // attribute area byte: header fields, then value bytes 2..7
               if (attr_offset_ff < 17'(srap_pkg::AttrHdrBytes)) begin
                  if (attr_offset_ff < 17'd2) begin
                     attr_type_in = {attr_type_ff[7:0], data_byte};
                  end else begin
                     attr_len_in = {attr_len_ff[7:0], data_byte};
                  end
               end else if (attr_offset_ff >= 17'd6 && attr_offset_ff < 17'd12) begin
                  pending_in = {pending_ff[39:0], data_byte};
               end
               // end of attribute: capture a match, restart the walk
               if (offset_inc >= 17'(srap_pkg::AttrHdrBytes) &&
                   offset_inc == 17'(attr_len_in) + 17'(srap_pkg::AttrHdrBytes)) begin
                  if (attr_type_in == wanted_attr_type &&
                      attr_len_in == 16'(srap_pkg::MappedValueLen)) begin
                     port_addr_in = pending_in;
                     found_in     = 1'b1;
                  end
                  attr_offset_in = '0;
               end else begin
                  attr_offset_in = offset_inc;
               end
            end
         end

         if (last_byte) begin
            count_ext             = ExtW'(byte_count_in);
            result.payload_length = count_ext[10:0];
            if (byte_count_in < CountW'(srap_pkg::HdrBytes)) begin
               result.status = srap_pkg::STATUS_SHORT;
            end else begin
               if (attr_offset_in == '0) begin
                  result.status = srap_pkg::STATUS_OK;
               end else if (attr_offset_in < 17'(srap_pkg::AttrHdrBytes)) begin
                  result.status = srap_pkg::STATUS_TRUNC_HDR;
               end else begin
                  result.status = srap_pkg::STATUS_OVERRUN;
               end
               result.found       = found_in;
               result.mapped_port = port_addr_in[47:32];
               result.mapped_addr = port_addr_in[31:0];
            end
            // datagram done: back to the reset state
            byte_count_in  = '0;
            hdr_len_in     = '0;
            attr_offset_in = '0;
            attr_type_in   = '0;
            attr_len_in    = '0;
            pending_in     = '0;
            port_addr_in   = '0;
            found_in       = 1'b0;
         end
      end
   end

   // Parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= '0;
         hdr_len_ff     <= '0;
         attr_offset_ff <= '0;
         attr_type_ff   <= '0;
         attr_len_ff    <= '0;
         pending_ff     <= '0;
         port_addr_ff   <= '0;
         found_ff       <= 1'b0;
      end else begin
         byte_count_ff  <= byte_count_in;
         hdr_len_ff     <= hdr_len_in;
         attr_offset_ff <= attr_offset_in;
         attr_type_ff   <= attr_type_in;
         attr_len_ff    <= attr_len_in;
         pending_ff     <= pending_in;
         port_addr_ff   <= port_addr_in;
         found_ff       <= found_in;
      end
   end

endmodule

`default_nettype wire

[src/stun_response_attribute_parser.sv]
// STUN response attribute parser, top level: stream ports, CSR, result register.
// Depends on srap_pkg and srap_parser.
//
// Usage:
//   req_*  : one payload byte per request, req_tlast on the final byte.
//   rsp_*  : one result per datagram, after the request carrying req_tlast.
//   csr_*  : writes wanted_attr_type; only while no datagram is in flight.
// Throughput is one byte per cycle, unless a final byte waits on a pending
// result; a byte only updates counters and compares between srap_parser regs.
// Latency: the result is valid in the cycle after the final byte is taken.
// Reset clears all parse state, drops rsp_tvalid and sets the wanted
// attribute type to 1. If the receiver stalls, the result stays in the
// output register; further non-final bytes are still taken, and only a
// final byte waits until the pending result has been accepted.
// Bytes beyond MAX_PAYLOAD_BYTES - 1 are neither counted nor parsed.
`default_nettype none

module stun_response_attribute_parser #(
   parameter int unsigned MAX_PAYLOAD_BYTES = 2048
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // last_byte
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [1:0] status, [12:2] payload_length,
                                         // [13] found, [29:14] mapped_port,
                                         // [61:30] mapped_addr, [63:62] zero
   // configuration write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data     // wanted_attr_type
);

   logic [15:0]          wanted_ff;
   logic                 rsp_valid_ff;
   srap_pkg::result_type rsp_data_ff;
   srap_pkg::result_type core_result;
   logic                 req_take;

   // A final byte needs a free output register; other bytes always pass
   assign req_tready = !rsp_valid_ff || rsp_tready || !req_tlast;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   srap_parser #(
      .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
   ) u_parser (
      .clock            (clock),
      .reset            (reset),
      .byte_valid       (req_take),
      .data_byte        (req_tdata),
      .last_byte        (req_tlast),
      .wanted_attr_type (wanted_ff),
      .result           (core_result)
   );

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_ff <= 16'(srap_pkg::WantedReset);
      end else if (csr_valid) begin
         wanted_ff <= csr_data;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take && req_tlast) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && req_tlast) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

`ifndef ASSERT_OFF
   // a result only appears after a final byte was taken
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast))
      else $error("result appeared without a final request byte");

   // every final byte taken yields a result in the next cycle
   a_rsp_follows : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> rsp_tvalid)
      else $error("final request byte did not produce a result");

   // short datagram reports nothing found
   a_short_empty : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_data_ff.status == srap_pkg::STATUS_SHORT) |->
      (!rsp_data_ff.found && rsp_data_ff.mapped_port == '0 &&
       rsp_data_ff.mapped_addr == '0))
      else $error("short datagram reported a mapped address");
`endif

endmodule

`default_nettype wire
